// ===== src/spq_pkg.sv =====
package spq_pkg;

   // Number of entries the queue holds.
   localparam int CAPACITY = 16;

   // Field widths of the request and response channels.
   localparam int DATA_W = 32;
   localparam int PRIO_W = 8;
   localparam int FILL_W = 5;
   localparam int STATUS_W = 2;

   // Width of the occupancy counter, wide enough to hold CAPACITY itself.
   localparam int COUNT_W = $clog2(CAPACITY + 1);

   // Operation codes on req_op.
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   // Result status codes.
   typedef enum logic [STATUS_W-1:0] {
      ST_INSERTED  = 2'd0,
      ST_REMOVED   = 2'd1,
      ST_UNDERFLOW = 2'd2,
      ST_OVERFLOW  = 2'd3
   } status_type;

   // One stored entry.
   typedef struct packed {
      logic [PRIO_W-1:0] prio;
      logic [DATA_W-1:0] data;
   } entry_type;

   // Command broadcast from the controller to every cell.
   typedef struct packed {
      logic      insert;
      logic      remove;
      entry_type fresh;
   } cell_cmd_type;

endpackage

// ===== src/spq_cell.sv =====
module spq_cell
   import spq_pkg::*;
(
   input  logic         clock,
   input  cell_cmd_type cmd,
   input  logic         occupied,
   input  logic         left_moves,
   input  entry_type    left_entry,
   input  entry_type    right_entry,
   output logic         moves,
   output entry_type    entry
);

   entry_type entry_ff;
   entry_type entry_in;

   // This entry is pushed one place toward the back when the new entry sorts ahead of it.
   assign moves = occupied && (entry_ff.prio > cmd.fresh.prio);

   // On insert, a cell that gives way takes either its left neighbor or the new entry.
   // On remove, every cell takes its right neighbor.
   always_comb begin
      entry_in = entry_ff;
      if (cmd.insert) begin
         if (left_moves) begin
            entry_in = left_entry;
         end else if (!occupied || moves) begin
            entry_in = cmd.fresh;
         end
      end else if (cmd.remove) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// ===== src/sorted_priority_queue_core.sv =====
// Sorted priority queue of CAPACITY entries, kept as a row of cells in ascending
// order of priority number; equal priorities leave in arrival order. Each accepted
// request (insert or remove) has its response in the output register on the next
// cycle, so one request can be taken every cycle while req_stall is low:
// every cell decides its move from its own priority compare and its left
// neighbor's compare alone. req_stall is high only while a response waits in the
// output register and rsp_stall holds it back. An insert into a full queue is
// dropped with status overflow, and a remove from an empty queue reports underflow.
module sorted_priority_queue_core
   import spq_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_op,
   input  logic signed [DATA_W-1:0]   req_item_data,
   input  logic        [PRIO_W-1:0]   req_item_priority,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic        [STATUS_W-1:0] rsp_status,
   output logic signed [DATA_W-1:0]   rsp_out_data,
   output logic        [PRIO_W-1:0]   rsp_out_priority,
   output logic        [FILL_W-1:0]   rsp_fill_count
);

   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;

   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   status_type         rsp_status_ff;
   status_type         rsp_status_in;
   logic [DATA_W-1:0]  rsp_data_ff;
   logic [DATA_W-1:0]  rsp_data_in;
   logic [PRIO_W-1:0]  rsp_prio_ff;
   logic [PRIO_W-1:0]  rsp_prio_in;
   logic [FILL_W-1:0]  rsp_fill_ff;
   logic [FILL_W-1:0]  rsp_fill_in;

   logic               accept;
   logic               full;
   logic               empty;
   logic               insert_ok;
   logic               remove_ok;
   cell_cmd_type       cmd;

   logic [CAPACITY-1:0] occupied;
   logic [CAPACITY-1:0] moves;
   entry_type           entries [CAPACITY];

   // A new request is taken unless a response waits in the output register with rsp_stall high.
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign full      = (count_ff == COUNT_W'(CAPACITY));
   assign empty     = (count_ff == '0);
   assign insert_ok = accept && (req_op == OP_INSERT) && !full;
   assign remove_ok = accept && (req_op == OP_REMOVE) && !empty;

   // Command seen by every cell.
   assign cmd.insert     = insert_ok;
   assign cmd.remove     = remove_ok;
   assign cmd.fresh.prio = req_item_priority;
   assign cmd.fresh.data = req_item_data;

   // Row of cells; cell zero holds the front of the queue.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      entry_type left_entry;
      entry_type right_entry;
      logic      left_moves;

      assign occupied[i] = (count_ff > COUNT_W'(i));

      if (i == 0) begin : g_head
         assign left_moves = 1'b0;
         assign left_entry = '0;
      end else begin : g_body
         assign left_moves = moves[i-1];
         assign left_entry = entries[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign right_entry = '0;
      end else begin : g_inner
         assign right_entry = entries[i+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .occupied    (occupied[i]),
         .left_moves  (left_moves),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .moves       (moves[i]),
         .entry       (entries[i])
      );
   end

   // Occupancy count and the response for the request taken in this cycle.
   always_comb begin
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_prio_in   = rsp_prio_ff;
      rsp_fill_in   = rsp_fill_ff;
      if (insert_ok) begin
         count_in = count_ff + COUNT_W'(1);
      end else if (remove_ok) begin
         count_in = count_ff - COUNT_W'(1);
      end
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = '0;
         rsp_prio_in  = '0;
         rsp_fill_in  = FILL_W'(count_in);
         if (req_op == OP_INSERT) begin
            rsp_status_in = full ? ST_OVERFLOW : ST_INSERTED;
         end else if (empty) begin
            rsp_status_in = ST_UNDERFLOW;
         end else begin
            rsp_status_in = ST_REMOVED;
            rsp_data_in   = entries[0].data;
            rsp_prio_in   = entries[0].prio;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_prio_ff   <= rsp_prio_in;
      rsp_fill_ff   <= rsp_fill_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_out_data     = rsp_data_ff;
   assign rsp_out_priority = rsp_prio_ff;
   assign rsp_fill_count   = rsp_fill_ff;

   // The count never exceeds the number of cells.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(CAPACITY))
      else $error("occupancy count exceeds capacity");

   // A remove from a non-empty queue yields a removed-entry response next cycle.
   assert property (@(posedge clock) disable iff (reset)
      remove_ok |=> (rsp_valid_ff && (rsp_status_ff == ST_REMOVED)))
      else $error("remove did not return an entry");

   // An underflow response can only be pending while the queue is empty.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == ST_UNDERFLOW)) |-> empty)
      else $error("underflow reported with entries stored");

   // Occupied cells stay in ascending order of priority number.
   for (genvar j = 0; j < CAPACITY - 1; j++) begin : g_order_chk
      assert property (@(posedge clock) disable iff (reset)
         occupied[j+1] |-> (entries[j].prio <= entries[j+1].prio))
         else $error("cell row out of priority order");
   end

endmodule

// ===== dv/tb_sorted_priority_queue_core.sv =====
module tb_sorted_priority_queue_core
   import spq_pkg::*;
;

   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_OFF_CYCLES = 80;

   // Shadow copy of the queue plus the responses still owed by the block.
   class priority_queue_scoreboard;
      typedef struct {
         status_type        status;
         logic [DATA_W-1:0] data;
         logic [PRIO_W-1:0] prio;
         logic [FILL_W-1:0] fill;
      } result_type;

      entry_type  stored[CAPACITY];
      int         stored_count;
      result_type awaited[$];
      int         errors;

      function new();
         stored_count = 0;
         errors = 0;
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      // Apply one accepted request to the shadow queue and record the response it owes.
      function void note_request(logic op, logic [DATA_W-1:0] data, logic [PRIO_W-1:0] prio);
         result_type r;
         int         slot;
         int         k;
         r.status = ST_INSERTED;
         r.data = '0;
         r.prio = '0;
         if (op == OP_INSERT) begin
            if (stored_count >= CAPACITY) begin
               r.status = ST_OVERFLOW;
            end else begin
               // The new entry goes behind every entry of equal or lower number.
               slot = 0;
               while (slot < stored_count && stored[slot].prio <= prio) slot++;
               for (k = stored_count; k > slot; k--) stored[k] = stored[k-1];
               stored[slot].prio = prio;
               stored[slot].data = data;
               stored_count++;
            end
         end else if (stored_count == 0) begin
            r.status = ST_UNDERFLOW;
         end else begin
            // Pop the front entry and close the gap.
            r.status = ST_REMOVED;
            r.data = stored[0].data;
            r.prio = stored[0].prio;
            for (k = 0; k + 1 < stored_count; k++) stored[k] = stored[k+1];
            stored_count--;
         end
         r.fill = FILL_W'(stored_count);
         awaited.push_back(r);
      endfunction

      // Compare one response transfer with the oldest owed response.
      function void check_response(logic [STATUS_W-1:0] status, logic [DATA_W-1:0] data,
                                   logic [PRIO_W-1:0] prio, logic [FILL_W-1:0] fill);
         result_type r;
         if (awaited.size() == 0) begin
            $display("%0t: response with no request outstanding, status %0d", $time, status);
            errors++;
            return;
         end
         r = awaited.pop_front();
         if (status !== r.status) begin
            $display("%0t: status expected %0d actual %0d", $time, r.status, status);
            errors++;
         end
         if (data !== r.data) begin
            $display("%0t: out_data expected %h actual %h", $time, r.data, data);
            errors++;
         end
         if (prio !== r.prio) begin
            $display("%0t: out_priority expected %0d actual %0d", $time, r.prio, prio);
            errors++;
         end
         if (fill !== r.fill) begin
            $display("%0t: fill_count expected %0d actual %0d", $time, r.fill, fill);
            errors++;
         end
      endfunction
   endclass

   logic                       clock;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic                       req_op = OP_INSERT;
   logic signed [DATA_W-1:0]   req_item_data = '0;
   logic        [PRIO_W-1:0]   req_item_priority = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic        [STATUS_W-1:0] rsp_status;
   logic signed [DATA_W-1:0]   rsp_out_data;
   logic        [PRIO_W-1:0]   rsp_out_priority;
   logic        [FILL_W-1:0]   rsp_fill_count;

   priority_queue_scoreboard sb;
   int  req_idle_pct = 8;
   int  rsp_stall_pct = 8;
   bit  hold_request = 1'b0;
   int  cycle_count = 0;

   sorted_priority_queue_core dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_op(req_op),
      .req_item_data(req_item_data),
      .req_item_priority(req_item_priority),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_out_data(rsp_out_data),
      .rsp_out_priority(rsp_out_priority),
      .rsp_fill_count(rsp_fill_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Run limit, in case the block stops answering.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Watch both channels; a transfer happens where valid is high and stall is low.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            sb.check_response(rsp_status, rsp_out_data, rsp_out_priority, rsp_fill_count);
         if (req_valid && !req_stall)
            sb.note_request(req_op, req_item_data, req_item_priority);
      end
   end

   // Receiver: random stalls, or a long hold-off when one is requested.
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_left = HOLD_OFF_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_stall = 1'b1;
            hold_left--;
         end else begin
            rsp_stall = ($urandom_range(0, 99) < rsp_stall_pct);
         end
      end
   end

   // Offer one request, with random idle cycles first, and wait for its transfer.
   task automatic send_item(input logic op, input logic [DATA_W-1:0] data,
                            input logic [PRIO_W-1:0] prio);
      @(negedge clock);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid = 1'b0;
         req_op = 1'($urandom);
         req_item_data = $urandom;
         req_item_priority = 8'($urandom);
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_op = op;
      req_item_data = data;
      req_item_priority = prio;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Stop offering and wait until every owed response has arrived.
   task automatic wait_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // Random mix; priorities mostly from a narrow band so ties are common.
   task automatic run_mix(input int count, input int insert_pct);
      logic              op;
      logic [PRIO_W-1:0] prio;
      repeat (count) begin
         op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_REMOVE;
         if ($urandom_range(0, 3) == 0)
            prio = 8'($urandom_range(0, 255));
         else
            prio = 8'($urandom_range(0, 7));
         send_item(op, $urandom, prio);
      end
   endtask

   initial begin
      logic [PRIO_W-1:0] fill_prios[16];
      logic [DATA_W-1:0] fill_data[4];
      int                i;
      fill_prios = '{8'd255, 8'd0, 8'd7, 8'd0, 8'd128, 8'd255, 8'd1, 8'd7,
                     8'd0, 8'd64, 8'd254, 8'd1, 8'd128, 8'd0, 8'd3, 8'd255};
      fill_data = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF};
      sb = new();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Remove from the empty queue, with the insert fields all ones.
      send_item(OP_REMOVE, 32'hFFFF_FFFF, 8'hFF);
      // Fill to capacity with extreme priorities, ties and extreme payloads.
      for (i = 0; i < 16; i++)
         send_item(OP_INSERT, (i < 4) ? fill_data[i] : $urandom, fill_prios[i]);
      // Insert into the full queue is dropped.
      send_item(OP_INSERT, 32'h7FFF_FFFF, 8'd0);
      send_item(OP_REMOVE, 32'hFFFF_FFFF, 8'hFF);
      send_item(OP_INSERT, 32'h8000_0000, 8'd255);
      repeat (3) send_item(OP_REMOVE, 32'h0, 8'h0);
      wait_drained();

      run_mix(120, 70);
      // Long receiver hold-off while requests keep coming, so the input backs up.
      hold_request = 1'b1;
      run_mix(120, 50);
      wait_drained();

      // A stretch without any idling on either side.
      req_idle_pct = 0;
      rsp_stall_pct = 0;
      run_mix(120, 85);
      req_idle_pct = 8;
      rsp_stall_pct = 8;
      wait_drained();

      run_mix(120, 20);
      run_mix(130, 50);
      wait_drained();
      run_mix(60, 90);
      run_mix(60, 10);
      wait_drained();

      repeat (4) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
